// ----- design/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding window maximum core: controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package swm_pkg;

    // width of the window size register
    localparam int WIN_BITS   = 7;
    // width of the running sample counter
    localparam int COUNT_BITS = 32;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXPIRE,
        S_UPDATE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture the incoming sample
        logic shift;   // drop the head entry
        logic update;  // prune the tail, append the sample, emit the result after warm-up
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic head_expired;  // head entry is older than the window
        logic out_busy;      // result register holds a result not yet taken
    } t_status;

endpackage

// ----- design/sliding_window_maximum_core.sv -----
// ----------------------------------------------------------------------------
// sliding_window_maximum_core
// Running maximum of the last window_size signed samples, kept in a
// monotonic queue of comparing cells.
//
//   channel   dir   handshake                    payload
//   s         in    i_s_tvalid / o_s_tready      i_s_tdata   sample
//   m         out   o_m_tvalid / i_m_tready      o_m_tdata   window_max
//   cfg       in    i_cfg_we                     i_cfg_wdata window_size
//
// one sample goes through capture, head check, prune and append; the head
// check drops the expiring head entries one per cycle (0 or 1 while
// the window is steady, up to MAX_WINDOW right after it shrinks)
// synchronous active-low reset empties the queue and sets the window to 1
// a result waits in the output register; the next sample is taken
// meanwhile and holds in the append step until the register is free
// ----------------------------------------------------------------------------
module sliding_window_maximum_core import swm_pkg::*; #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side: bits [SAMPLE_BITS-1:0] sample, zero padded to bytes
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     i_s_tdata,
    // master side: bits [SAMPLE_BITS-1:0] window_max, zero padded to bytes
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     o_m_tdata,
    // window size register
    input  logic                                 i_cfg_we,
    input  logic [WIN_BITS-1:0]                  i_cfg_wdata
);

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

    t_cmd                          cmd;
    t_status                       status;
    logic signed [SAMPLE_BITS-1:0] out_data;

    // sequencer
    swm_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // queue cells and result register
    swm_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (out_data)
    );

    // zero fill to whole bytes
    assign o_m_tdata = DW'(unsigned'(out_data));

endmodule

// ----- design/swm_controller.sv -----
// ----------------------------------------------------------------------------
// swm_controller
// Sequencer for one sample: capture, head expiry one entry per cycle, then
// the tail prune and append once the result register has room.
// ----------------------------------------------------------------------------
module swm_controller import swm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXPIRE;
                end
            end
            S_EXPIRE: begin
                if (i_status.head_expired) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                if (!i_status.out_busy) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/swm_datapath.sv -----
// ----------------------------------------------------------------------------
// swm_datapath
// Row of comparing cells holding the monotonic queue (value, age, valid),
// the window size register, the sample counter and the result register.
// ----------------------------------------------------------------------------
module swm_datapath import swm_pkg::*; #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [WIN_BITS-1:0]           i_cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  t_cmd                          i_cmd,
    output t_status                       o_status,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic signed [SAMPLE_BITS-1:0] o_out_data
);

    localparam int AGE_BITS = $clog2(MAX_WINDOW + 1);
    localparam int WW       = (AGE_BITS > WIN_BITS) ? AGE_BITS : WIN_BITS;

    // queue cells, head at index 0
    logic signed [SAMPLE_BITS-1:0] r_val [MAX_WINDOW];
    logic        [AGE_BITS-1:0]    r_age [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]  r_vld;
    logic signed [SAMPLE_BITS-1:0] n_val [MAX_WINDOW];
    logic        [AGE_BITS-1:0]    n_age [MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]  n_vld;

    logic [WIN_BITS-1:0]           r_win;
    logic [COUNT_BITS-1:0]         r_count;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [WW-1:0]         w_ext;
    logic [WW-1:0]         w_eff;
    logic [MAX_WINDOW-1:0] keep;
    logic                  full;
    logic                  due;

    // effective window: zero acts as one, saturate at the queue depth
    always_comb begin
        w_ext = WW'(r_win);
        if (w_ext == '0) begin
            w_eff = WW'(1);
        end else if (w_ext > WW'(MAX_WINDOW)) begin
            w_eff = WW'(MAX_WINDOW);
        end else begin
            w_eff = w_ext;
        end
    end

    // status towards the controller
    assign o_status.head_expired = r_vld[0] && (WW'(r_age[0]) >= w_eff);
    assign o_status.out_busy     = r_out_vld && !i_out_ready;

    // warm-up test on the position of this sample
    assign due = r_count >= (COUNT_BITS'(w_eff) - COUNT_BITS'(1));

    // per-cell keep flags: entries greater than the new sample survive
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            keep[i] = r_vld[i] && (r_val[i] > r_sample);
        end
    end
    assign full = keep[MAX_WINDOW-1];

    // next cell contents
    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            n_val[i] = r_val[i];
            n_age[i] = r_age[i];
            n_vld[i] = r_vld[i];
        end
        if (i_cmd.shift) begin
            // head expiry: everything moves one place towards the head
            for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                n_val[i] = r_val[i+1];
                n_age[i] = r_age[i+1];
                n_vld[i] = r_vld[i+1];
            end
            n_vld[MAX_WINDOW-1] = 1'b0;
        end else if (i_cmd.update) begin
            if (full) begin
                // queue full with nothing pruned: drop head, append at tail
                for (int i = 0; i < MAX_WINDOW - 1; i++) begin
                    n_val[i] = r_val[i+1];
                    n_age[i] = r_age[i+1] + AGE_BITS'(1);
                    n_vld[i] = 1'b1;
                end
                n_val[MAX_WINDOW-1] = r_sample;
                n_age[MAX_WINDOW-1] = AGE_BITS'(1);
                n_vld[MAX_WINDOW-1] = 1'b1;
            end else begin
                // survivors age, first free cell after them takes the sample
                for (int i = 0; i < MAX_WINDOW; i++) begin
                    if (keep[i]) begin
                        n_age[i] = r_age[i] + AGE_BITS'(1);
                        n_vld[i] = 1'b1;
                    end else if ((i == 0) || keep[(i == 0) ? 0 : i-1]) begin
                        n_val[i] = r_sample;
                        n_age[i] = AGE_BITS'(1);
                        n_vld[i] = 1'b1;
                    end else begin
                        n_vld[i] = 1'b0;
                    end
                end
            end
        end
    end

    // cell payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            r_val[i] <= n_val[i];
            r_age[i] <= n_age[i];
        end
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
        if (i_cmd.update && due) begin
            r_out <= n_val[0];
        end
    end

    // control state: valid bits, window, counter, result flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_win     <= WIN_BITS'(1);
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_cfg_we) begin
                r_win <= i_cfg_wdata;
            end
            if (i_cmd.update) begin
                r_count <= r_count + COUNT_BITS'(1);
            end
            if (i_cmd.update && due) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ----- design/swm_checker.sv -----
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sliding window maximum core, bound to the top.
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*; #(
    parameter int DW = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_s_tvalid,
    input logic          o_s_tready,
    input logic          o_m_tvalid,
    input logic          i_m_tready,
    input logic [DW-1:0] o_m_tdata
);

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // one sample in flight: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second sample taken while one is in flight");

    // a sample passes the head check and the prune and append before ready returns
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> ##1 !o_s_tready)
        else $error("sample finished too early");

endmodule

bind sliding_window_maximum_core swm_checker #(
    .DW (((SAMPLE_BITS + 7) / 8) * 8)
) u_swm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
